// ===== src/nrht_pkg.sv =====
// ----------------------------------------------------------------------------
// nrht_pkg
// Shared constants, types and codes for the nearest rectangle hit test.
// ----------------------------------------------------------------------------
package nrht_pkg;

	// table geometry
	localparam int MAX_KEYS   = 64;
	localparam int COORD_BITS = 11;

	// field widths fixed by the interface
	localparam int LEN_BITS       = 10;
	localparam int KEY_INDEX_BITS = 6;
	localparam int COUNT_BITS     = 7;
	localparam int REACH_BITS     = 10;
	localparam int CFG_DATA_BITS  = 10;
	localparam int CFG_INDEX_BITS = 1;

	// derived widths
	localparam int IDX_BITS = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CNT_BITS = IDX_BITS + 1;
	localparam int EXT_BITS = ((COORD_BITS > LEN_BITS) ? COORD_BITS : LEN_BITS) + 2;
	localparam int GAP_BITS = EXT_BITS - 1;
	localparam int SQ_BITS  = 2 * GAP_BITS;
	localparam int SUM_BITS = SQ_BITS + 1;

	// request codes
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_KEY_COUNT = 1'b0,
		CFG_REACH     = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] lft;
		logic signed [COORD_BITS-1:0] top;
		logic [LEN_BITS-1:0]          wid;
		logic [LEN_BITS-1:0]          hgt;
	} rect_t;

	localparam int RECT_BITS = $bits(rect_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic wr_entry;
		logic start_query;
		logic issue;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic pipe_busy;
	} dp_stat_t;

endpackage

// ===== src/nrht_ram.sv =====
// ----------------------------------------------------------------------------
// nrht_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module nrht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/nrht_ctrl.sv =====
// ----------------------------------------------------------------------------
// nrht_ctrl
// Sequencer for the hit test: takes items, steps the table scan, waits for
// the compare pipeline to empty and hands the result to the output register.
// ----------------------------------------------------------------------------
module nrht_ctrl
	import nrht_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      req_type,
	output logic      out_valid,
	input  logic      out_ready,
	output ctrl_cmd_t cmd,
	input  dp_stat_t  stat
);

	state_t state_q, state_next;
	logic   out_valid_q;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && (req_type == REQ_QUERY)) begin
					state_next = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.scan_done) begin
					state_next = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_next = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready        = 1'b0;
		cmd.wr_entry    = 1'b0;
		cmd.start_query = 1'b0;
		cmd.issue       = 1'b0;
		cmd.load_out    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready        = 1'b1;
				cmd.wr_entry    = in_valid && (req_type == REQ_WRITE);
				cmd.start_query = in_valid && (req_type == REQ_QUERY);
			end
			ST_SCAN: begin
				cmd.issue = !stat.scan_done;
			end
			ST_DRAIN: begin
			end
			ST_FINISH: begin
				cmd.load_out = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/nrht_dp.sv =====
// ----------------------------------------------------------------------------
// nrht_dp
// Datapath: configuration registers, rectangle memory, address counter and
// a three-stage gap / square / compare pipeline with the running best.
// ----------------------------------------------------------------------------
module nrht_dp
	import nrht_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [CFG_DATA_BITS-1:0]     cfg_data,
	input  logic [KEY_INDEX_BITS-1:0]    key_index,
	input  logic signed [COORD_BITS-1:0] key_left,
	input  logic signed [COORD_BITS-1:0] key_top,
	input  logic [LEN_BITS-1:0]          key_width,
	input  logic [LEN_BITS-1:0]          key_height,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  ctrl_cmd_t                    cmd,
	output dp_stat_t                     stat,
	output logic                         hit,
	output logic [KEY_INDEX_BITS-1:0]    hit_index
);

	logic [COUNT_BITS-1:0] key_count_q;
	logic [REACH_BITS-1:0] reach_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
			reach_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_KEY_COUNT: key_count_q <= cfg_data[COUNT_BITS-1:0];
				CFG_REACH:     reach_q     <= cfg_data[REACH_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// rectangle memory
	logic                wr_ok;
	rect_t               wr_rect;
	logic [RECT_BITS-1:0] rd_data;
	rect_t               rd_rect;
	logic [CNT_BITS-1:0] cnt_q;
	logic [CNT_BITS-1:0] n_q;

	assign wr_ok = cmd.wr_entry && (32'(key_index) < MAX_KEYS);

	always_comb begin
		wr_rect.lft = key_left;
		wr_rect.top = key_top;
		wr_rect.wid = key_width;
		wr_rect.hgt = key_height;
	end

	nrht_ram #(
		.WIDTH (RECT_BITS),
		.DEPTH (MAX_KEYS)
	) u_ram (
		.clk   (clk),
		.we    (wr_ok),
		.waddr (IDX_BITS'(key_index)),
		.wdata (wr_rect),
		.re    (cmd.issue),
		.raddr (cnt_q[IDX_BITS-1:0]),
		.rdata (rd_data)
	);

	assign rd_rect = rect_t'(rd_data);

	// query set-up and scan counter
	logic signed [COORD_BITS-1:0] px_q, py_q;
	logic [2*REACH_BITS-1:0]      reach_sq;
	logic [SUM_BITS-1:0]          best_d_q;
	logic                         found_q;
	logic [IDX_BITS-1:0]          best_idx_q;

	assign reach_sq = reach_q * reach_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			n_q   <= '0;
		end else if (cmd.start_query) begin
			cnt_q <= '0;
			n_q   <= (32'(key_count_q) > MAX_KEYS) ? CNT_BITS'(MAX_KEYS)
				: CNT_BITS'(key_count_q);
		end else if (cmd.issue) begin
			cnt_q <= cnt_q + CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_query) begin
			px_q <= point_x;
			py_q <= point_y;
		end
	end

	assign stat.scan_done = (cnt_q == n_q);

	// pipeline valids
	logic v_s0, v_s1, v_s2;
	logic [IDX_BITS-1:0] idx_s0, idx_s1, idx_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s0 <= cmd.issue;
			v_s1 <= v_s0;
			v_s2 <= v_s1;
		end
	end

	assign stat.pipe_busy = v_s0 || v_s1 || v_s2;

	// stage 1: per-axis gap to the rectangle
	logic signed [EXT_BITS-1:0] pxe, pye, lo_x, lo_y, hi_x, hi_y;
	logic [GAP_BITS-1:0]        gx, gy;
	logic [GAP_BITS-1:0]        gx_s1, gy_s1;

	always_comb begin
		pxe  = EXT_BITS'(px_q);
		pye  = EXT_BITS'(py_q);
		lo_x = EXT_BITS'(rd_rect.lft);
		lo_y = EXT_BITS'(rd_rect.top);
		// last column / row is one before edge plus length
		hi_x = lo_x + $signed(EXT_BITS'(rd_rect.wid)) - EXT_BITS'(1);
		hi_y = lo_y + $signed(EXT_BITS'(rd_rect.hgt)) - EXT_BITS'(1);
		if (pxe < lo_x) begin
			gx = GAP_BITS'(lo_x - pxe);
		end else if (pxe > hi_x) begin
			gx = GAP_BITS'(pxe - hi_x);
		end else begin
			gx = '0;
		end
		if (pye < lo_y) begin
			gy = GAP_BITS'(lo_y - pye);
		end else if (pye > hi_y) begin
			gy = GAP_BITS'(pye - hi_y);
		end else begin
			gy = '0;
		end
	end

	// stage 2: squares
	logic [SQ_BITS-1:0] sqx_s2, sqy_s2;

	always_ff @(posedge clk) begin
		idx_s0 <= cnt_q[IDX_BITS-1:0];
		idx_s1 <= idx_s0;
		idx_s2 <= idx_s1;
		gx_s1  <= gx;
		gy_s1  <= gy;
		sqx_s2 <= gx_s1 * gx_s1;
		sqy_s2 <= gy_s1 * gy_s1;
	end

	// stage 3: sum and keep the first strictly smaller distance
	logic [SUM_BITS-1:0] sum_d;

	assign sum_d = SUM_BITS'(sqx_s2) + SUM_BITS'(sqy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.start_query) begin
			found_q <= 1'b0;
		end else if (v_s2 && (sum_d < best_d_q)) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_query) begin
			best_d_q   <= SUM_BITS'(reach_sq) + SUM_BITS'(1);
			best_idx_q <= '0;
		end else if (v_s2 && (sum_d < best_d_q)) begin
			best_d_q   <= sum_d;
			best_idx_q <= idx_s2;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			hit       <= found_q;
			hit_index <= KEY_INDEX_BITS'(best_idx_q);
		end
	end

endmodule

// ===== src/nearest_rect_hit_test.sv =====
// ----------------------------------------------------------------------------
// nearest_rect_hit_test
// Table of screen rectangles searched for the nearest one to a touch point.
// ----------------------------------------------------------------------------
// A write item stores one rectangle and gives no result. A query item scans
// the first key_count entries (at most 64) one entry per cycle through the
// single read port of the rectangle memory, followed by a three-stage gap,
// square and compare pipeline; no new item is accepted until the scan is
// done, the pipeline has drained and the result has been loaded into the
// output register, which waits while the previous result still sits there
// unclaimed. That register lets a new item be taken while its result is
// still unclaimed. Entries read by a query must have been written first.
module nearest_rect_hit_test
	import nrht_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [CFG_DATA_BITS-1:0]     cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         req_type,
	input  logic [KEY_INDEX_BITS-1:0]    key_index,
	input  logic signed [COORD_BITS-1:0] key_left,
	input  logic signed [COORD_BITS-1:0] key_top,
	input  logic [LEN_BITS-1:0]          key_width,
	input  logic [LEN_BITS-1:0]          key_height,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit,
	output logic [KEY_INDEX_BITS-1:0]    hit_index
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	nrht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	nrht_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.key_index  (key_index),
		.key_left   (key_left),
		.key_top    (key_top),
		.key_width  (key_width),
		.key_height (key_height),
		.point_x    (point_x),
		.point_y    (point_y),
		.cmd        (cmd),
		.stat       (stat),
		.hit        (hit),
		.hit_index  (hit_index)
	);

endmodule

// ===== src/nrht_checker.sv =====
// ----------------------------------------------------------------------------
// nrht_checker
// Port-level checks for the nearest rectangle hit test, bound to the top.
// ----------------------------------------------------------------------------
module nrht_checker
	import nrht_pkg::*;
(
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cfg_we,
	input logic [CFG_INDEX_BITS-1:0]    cfg_index,
	input logic [CFG_DATA_BITS-1:0]     cfg_data,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         req_type,
	input logic [KEY_INDEX_BITS-1:0]    key_index,
	input logic signed [COORD_BITS-1:0] key_left,
	input logic signed [COORD_BITS-1:0] key_top,
	input logic [LEN_BITS-1:0]          key_width,
	input logic [LEN_BITS-1:0]          key_height,
	input logic signed [COORD_BITS-1:0] point_x,
	input logic signed [COORD_BITS-1:0] point_y,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         hit,
	input logic [KEY_INDEX_BITS-1:0]    hit_index
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(hit_index))
		else $error("result changed while stalled");

	// a miss reports index zero
	a_miss_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> hit_index == '0)
		else $error("miss with nonzero index");

	// a query keeps the input closed while it scans
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (req_type == REQ_QUERY) |=> !in_ready)
		else $error("input open right after a query item");

	// a write item makes no result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (req_type == REQ_WRITE) && !out_valid |=> !out_valid)
		else $error("result after a write item");

endmodule

bind nearest_rect_hit_test nrht_checker u_nrht_checker (.*);

// ===== tb/nearest_rect_hit_test_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_rect_hit_test_tb
// Self-checking bench for the rectangle table and nearest-hit search.
// ----------------------------------------------------------------------------
// Rectangles are written into the table and touch points are queried under
// several key count and reach settings. A local copy of the table predicts
// the hit and index of each query, and every result is compared against the
// oldest prediction. Both handshakes see random gaps and stalls.
module nearest_rect_hit_test_tb
	import nrht_pkg::*;
();

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 80;

	// receiver stall patterns
	localparam int RX_STREAM = 0;
	localparam int RX_JITTER = 1;
	localparam int RX_BURSTY = 2;

	typedef struct {
		logic                         kind;
		logic [KEY_INDEX_BITS-1:0]    slot;
		rect_t                        shape;
		logic signed [COORD_BITS-1:0] px;
		logic signed [COORD_BITS-1:0] py;
	} touch_req_t;

	typedef struct {
		logic                      hit;
		logic [KEY_INDEX_BITS-1:0] hit_index;
	} hit_result_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0]    cfg_index = CFG_KEY_COUNT;
	logic [CFG_DATA_BITS-1:0]     cfg_data = '0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic                         req_type = REQ_WRITE;
	logic [KEY_INDEX_BITS-1:0]    key_index = '0;
	logic signed [COORD_BITS-1:0] key_left = '0;
	logic signed [COORD_BITS-1:0] key_top = '0;
	logic [LEN_BITS-1:0]          key_width = '0;
	logic [LEN_BITS-1:0]          key_height = '0;
	logic signed [COORD_BITS-1:0] point_x = '0;
	logic signed [COORD_BITS-1:0] point_y = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic                         hit;
	logic [KEY_INDEX_BITS-1:0]    hit_index;

	// local copy of the block state
	rect_t key_table [MAX_KEYS];
	int    cur_key_count = 0;
	int    cur_reach = 0;

	hit_result_t expected_hits [$];
	int          fail_count = 0;
	int          cycle_count = 0;
	int          burst_left = 0;
	int          rx_mode = RX_STREAM;
	int          rx_stall = 0;
	int          rx_cycles = 0;

	nearest_rect_hit_test DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.key_index  (key_index),
		.key_left   (key_left),
		.key_top    (key_top),
		.key_width  (key_width),
		.key_height (key_height),
		.point_x    (point_x),
		.point_y    (point_y),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit),
		.hit_index  (hit_index)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic longint axis_gap(int p, int lo, int len);
		int hi;
		hi = lo + len - 1;
		if (p < lo)
			return longint'(lo - p);
		if (p > hi)
			return longint'(p - hi);
		return 0;
	endfunction

	function automatic hit_result_t predict_hit(logic signed [COORD_BITS-1:0] px,
			logic signed [COORD_BITS-1:0] py);
		hit_result_t res;
		longint      best_d;
		longint      d;
		longint      dx;
		longint      dy;
		int          n;
		res.hit = 1'b0;
		res.hit_index = '0;
		n = (cur_key_count > MAX_KEYS) ? MAX_KEYS : cur_key_count;
		best_d = longint'(cur_reach) * cur_reach + 1;
		for (int i = 0; i < n; i++) begin
			dx = axis_gap(int'(px), int'(key_table[i].lft), int'(key_table[i].wid));
			dy = axis_gap(int'(py), int'(key_table[i].top), int'(key_table[i].hgt));
			d = dx * dx + dy * dy;
			// strict compare keeps the lowest index on ties
			if (d < best_d) begin
				best_d = d;
				res.hit = 1'b1;
				res.hit_index = KEY_INDEX_BITS'(i);
			end
		end
		return res;
	endfunction

	function automatic void apply_request(touch_req_t r);
		if (r.kind == REQ_WRITE)
			key_table[r.slot] = r.shape;
		else
			expected_hits.push_back(predict_hit(r.px, r.py));
	endfunction

	// ---------------------------------------------------------------- checker

	always @(posedge clk) begin
		hit_result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (expected_hits.size() == 0) begin
				$error("result with none expected: hit %0d hit_index %0d", hit, hit_index);
				fail_count++;
			end else begin
				exp_res = expected_hits.pop_front();
				if (hit !== exp_res.hit) begin
					$error("hit: expected %0d, got %0d", exp_res.hit, hit);
					fail_count++;
				end
				if (hit_index !== exp_res.hit_index) begin
					$error("hit_index: expected %0d, got %0d", exp_res.hit_index, hit_index);
					fail_count++;
				end
			end
		end
	end

	// receiver switches at random between its stall patterns
	always @(posedge clk) begin
		rx_cycles++;
		if (rx_cycles % 512 == 0)
			rx_mode = $urandom_range(RX_BURSTY);
		if (rx_stall > 0) begin
			rx_stall--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_STREAM: rx_stall = 0;
				RX_JITTER: rx_stall = ($urandom_range(9) < 3) ? $urandom_range(1, 3) : 0;
				default: rx_stall = ($urandom_range(19) == 0) ? $urandom_range(10, 40) : 0;
			endcase
			out_ready <= (rx_stall == 0);
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic int clamp_coord(int v);
		if (v < -1024)
			return -1024;
		if (v > 1023)
			return 1023;
		return v;
	endfunction

	function automatic int rand_coord();
		case ($urandom_range(9))
			0: return -1024;
			1: return 1023;
			default: return int'($urandom_range(2047)) - 1024;
		endcase
	endfunction

	function automatic int rand_len();
		case ($urandom_range(9))
			0: return 0;
			1: return 1023;
			2, 3, 4: return $urandom_range(1023);
			default: return $urandom_range(40);
		endcase
	endfunction

	function automatic rect_t random_rect();
		rect_t r;
		r.lft = COORD_BITS'(rand_coord());
		r.top = COORD_BITS'(rand_coord());
		r.wid = LEN_BITS'(rand_len());
		r.hgt = LEN_BITS'(rand_len());
		return r;
	endfunction

	function automatic touch_req_t random_request(int write_pct);
		touch_req_t r;
		rect_t      near;
		int         n;
		r.slot = KEY_INDEX_BITS'($urandom_range(MAX_KEYS - 1));
		r.px = COORD_BITS'(rand_coord());
		r.py = COORD_BITS'(rand_coord());
		r.shape = random_rect();
		if ($urandom_range(99) < write_pct) begin
			r.kind = REQ_WRITE;
			// duplicate an entry now and then to provoke ties
			if ($urandom_range(6) == 0)
				r.shape = key_table[$urandom_range(MAX_KEYS - 1)];
		end else begin
			r.kind = REQ_QUERY;
			n = (cur_key_count > MAX_KEYS) ? MAX_KEYS : cur_key_count;
			if (n == 0)
				n = MAX_KEYS;
			if ($urandom_range(4) < 3) begin
				near = key_table[$urandom_range(n - 1)];
				r.px = COORD_BITS'(clamp_coord(int'(near.lft)
					+ int'($urandom_range(int'(near.wid) + 16)) - 8));
				r.py = COORD_BITS'(clamp_coord(int'(near.top)
					+ int'($urandom_range(int'(near.hgt) + 16)) - 8));
			end
		end
		return r;
	endfunction

	task automatic send_request(input touch_req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid   <= 1'b1;
		req_type   <= r.kind;
		key_index  <= r.slot;
		key_left   <= r.shape.lft;
		key_top    <= r.shape.top;
		key_width  <= r.shape.wid;
		key_height <= r.shape.hgt;
		point_x    <= r.px;
		point_y    <= r.py;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		apply_request(r);
	endtask

	task automatic send_write(input int slot, input int l, input int t, input int w, input int h);
		touch_req_t r;
		r = random_request(100);
		r.slot = KEY_INDEX_BITS'(slot);
		r.shape.lft = COORD_BITS'(l);
		r.shape.top = COORD_BITS'(t);
		r.shape.wid = LEN_BITS'(w);
		r.shape.hgt = LEN_BITS'(h);
		send_request(r);
	endtask

	task automatic send_query(input int x, input int y);
		touch_req_t r;
		r = random_request(0);
		r.px = COORD_BITS'(x);
		r.py = COORD_BITS'(y);
		send_request(r);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_hits.size() != 0);
	endtask

	// registers change only once the block has gone quiet
	task automatic program_regs(input int count, input int reach_px);
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_KEY_COUNT;
		cfg_data  <= count[CFG_DATA_BITS-1:0];
		@(posedge clk);
		cur_key_count = count & 'h7f;
		cfg_index <= CFG_REACH;
		cfg_data  <= reach_px[CFG_DATA_BITS-1:0];
		@(posedge clk);
		cur_reach = reach_px & 'h3ff;
		cfg_we <= 1'b0;
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_empty_search();
		send_query(0, 0);
		send_query(-1024, 1023);
	endtask

	task automatic test_edge_cases();
		send_write(0, -1024, -1024, 1023, 1023);
		// zero-size rectangle contains no pixel, not even its corner
		send_write(1, 100, 100, 0, 0);
		send_write(2, 500, 500, 10, 10);
		send_write(3, 500, 500, 10, 10);
		send_write(63, 1023, 1023, 1023, 1023);

		// reach of zero only counts points inside
		program_regs(4, 0);
		send_query(-1024, -1024);
		send_query(505, 505);
		send_query(99, 99);
		send_query(100, 100);
		send_query(1023, 1023);

		program_regs(4, 1023);
		send_query(100, 100);
		send_query(1023, 1023);
		send_query(1023, -1024);

		// distance exactly reach squared hits, one more misses
		program_regs(1, 5);
		send_query(3, -2);
		send_query(4, -2);
		send_query(2, -1);
	endtask

	task automatic test_fill_table();
		for (int i = 0; i < MAX_KEYS; i++) begin
			send_write(i, rand_coord(), rand_coord(), rand_len(), rand_len());
		end
	endtask

	task automatic run_phase(input int count, input int reach_px, input int n_items);
		program_regs(count, reach_px);
		for (int k = 0; k < n_items; k++) begin
			if (k == n_items / 2)
				wait_for_results();
			send_request(random_request(20));
		end
	endtask

	task automatic test_random_traffic();
		int fixed_count [5] = '{64, 64, 127, 0, 1};
		int fixed_reach [5] = '{1023, 0, 300, 500, 1023};
		for (int p = 0; p < 5; p++) begin
			run_phase(fixed_count[p], fixed_reach[p], 76);
		end
		for (int p = 0; p < 5; p++) begin
			run_phase($urandom_range(1, MAX_KEYS),
				($urandom_range(1) == 0) ? $urandom_range(40) : $urandom_range(1023), 76);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_search();
		test_edge_cases();
		test_fill_table();
		test_random_traffic();

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
